// ----- src/pse_pkg.sv -----
// Shared types, register map and reset values of the PCM silence end detector.
package pse_pkg;

  localparam int SampleWidth = 16;
  localparam int MagWidth    = 17;
  localparam int LenWidth    = 16;
  localparam int ThrWidth    = 15;
  localparam int RunWidth    = 16;
  localparam int IndexWidth  = 31;
  localparam int SumWidth    = 32;
  localparam int LoudWidth   = 16;
  localparam int AddrWidth   = 4;
  localparam int DataWidth   = 32;

  localparam logic [LenWidth-1:0]   FrameLengthReset  = 16'd8192;
  localparam logic [ThrWidth-1:0]   ThresholdReset    = 15'd16;
  localparam logic [RunWidth-1:0]   SilentLimitReset  = 16'd30;
  localparam logic [IndexWidth-1:0] MaxFramesReset    = 31'h7fff_ffff;
  localparam logic [RunWidth-1:0]   RunSaturate       = 16'hffff;

  typedef enum logic [1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_SILENT_LIMIT = 2'd2,
    REG_MAX_FRAMES   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,
    STOP_SILENCE = 2'd1,
    STOP_LIMIT   = 2'd2
  } stop_code_t;

  typedef struct packed {
    logic                  frame_blank;
    logic [RunWidth-1:0]   silent_run;
    logic [IndexWidth-1:0] frame_index;
    stop_code_t            stop_code;
  } result_t;

endpackage

// ----- src/pse_sample_if.sv -----
// Request channel carrying one signed PCM value.
interface pse_sample_if;
  import pse_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- src/pse_result_if.sv -----
// Request channel carrying one finished-frame report.
interface pse_result_if;
  import pse_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  frame_blank;
  logic [RunWidth-1:0]   silent_run;
  logic [IndexWidth-1:0] frame_index;
  stop_code_t            stop_code;

  modport source (output valid, output frame_blank, output silent_run,
                  output frame_index, output stop_code, input ready);
  modport sink (input valid, input frame_blank, input silent_run,
                input frame_index, input stop_code, output ready);
endinterface

// ----- src/pcm_silence_end_detector_top.sv -----
// PCM silence end detector: frames PCM values and reports silence and stop decisions.
//
// samples carries one signed 16-bit PCM value per request; results carries one
// report per finished frame (blank flag, silent run, frame index, stop code).
// The user must write registers over the APB port only while the block is idle;
// the block itself does not enforce this. A value is registered in the input
// register on acceptance (magnitude and loud test), and from there it updates
// the frame accumulators; a frame end writes its report into the output
// register. One value is taken every cycle while samples.ready is high; the
// frame accumulator update in the second stage sets that rate.
// A two-entry output buffer (output register plus skid register) lets input
// continue while a report waits. When both entries are full and the receiver
// stalls, a value that would end a frame waits in the input register and
// samples.ready drops until the receiver takes a report.
// After a report with a nonzero stop code, all further values are accepted
// and dropped until reset.
// Reset (rst, synchronous) loads the register defaults, clears all
// accumulators and counters and empties both stages.
module pcm_silence_end_detector_top (
  input  logic                           clk,
  input  logic                           rst,
  pse_sample_if.sink                     samples,
  pse_result_if.source                   results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pse_pkg::AddrWidth-1:0]  paddr,
  input  logic [pse_pkg::DataWidth-1:0]  pwdata,
  output logic [pse_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);
  import pse_pkg::*;

  logic [LenWidth-1:0]   frame_length;
  logic [ThrWidth-1:0]   amplitude_threshold;
  logic [RunWidth-1:0]   silent_frame_limit;
  logic [IndexWidth-1:0] max_frames;

  logic                  s1_valid;
  logic [MagWidth-1:0]   s1_mag;
  logic                  s1_loud;

  logic [LenWidth-1:0]   position_in_frame;
  logic [LoudWidth-1:0]  loud_count;
  logic [SumWidth-1:0]   magnitude_sum;
  logic [RunWidth-1:0]   blank_run;
  logic [IndexWidth-1:0] frames_done;
  logic                  finished;

  logic                  out_valid;
  result_t               out_data;
  logic                  skid_valid;
  result_t               skid_data;

  logic                  cfg_write;
  reg_index_t            cfg_index;
  logic [MagWidth-1:0]   in_mag;
  logic [LoudWidth-1:0]  loud_count_next;
  logic [SumWidth-1:0]   magnitude_sum_next;
  logic [LenWidth:0]     position_plus;
  logic                  frame_end;
  logic [19:0]           loud_times_ten;
  logic                  blank;
  logic [RunWidth-1:0]   blank_run_next;
  logic [IndexWidth:0]   frames_plus;
  stop_code_t            code;
  logic                  s1_fire;
  logic                  push;
  logic                  pop;
  logic                  in_fire;
  result_t               result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[AddrWidth-1:2]);

  always_comb begin
    case (cfg_index)
      REG_FRAME_LENGTH: prdata = {{(DataWidth-LenWidth){1'b0}}, frame_length};
      REG_THRESHOLD:    prdata = {{(DataWidth-ThrWidth){1'b0}}, amplitude_threshold};
      REG_SILENT_LIMIT: prdata = {{(DataWidth-RunWidth){1'b0}}, silent_frame_limit};
      REG_MAX_FRAMES:   prdata = {{(DataWidth-IndexWidth){1'b0}}, max_frames};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length        <= FrameLengthReset;
      amplitude_threshold <= ThresholdReset;
      silent_frame_limit  <= SilentLimitReset;
      max_frames          <= MaxFramesReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_LENGTH: frame_length        <= pwdata[LenWidth-1:0];
        REG_THRESHOLD:    amplitude_threshold <= pwdata[ThrWidth-1:0];
        REG_SILENT_LIMIT: silent_frame_limit  <= pwdata[RunWidth-1:0];
        REG_MAX_FRAMES:   max_frames          <= pwdata[IndexWidth-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: magnitude and loud test.
  assign in_mag = samples.sample[SampleWidth-1]
                ? MagWidth'(17'h10000 - {1'b0, samples.sample})
                : {1'b0, samples.sample};

  // Stage 2: frame accumulation and frame-end decision.
  assign loud_count_next    = loud_count + LoudWidth'(s1_loud);
  assign magnitude_sum_next = magnitude_sum + {{(SumWidth-MagWidth){1'b0}}, s1_mag};
  assign position_plus      = {1'b0, position_in_frame} + 17'd1;
  assign frame_end          = position_plus >= {1'b0, frame_length};
  assign loud_times_ten     = {1'b0, loud_count_next, 3'b000}
                            + {3'b000, loud_count_next, 1'b0};
  assign blank              = (magnitude_sum_next == '0)
                            || (loud_times_ten < {4'b0000, frame_length});
  assign frames_plus        = {1'b0, frames_done} + 32'd1;

  always_comb begin
    if (!blank) begin
      blank_run_next = '0;
    end else if (blank_run == RunSaturate) begin
      blank_run_next = blank_run;
    end else begin
      blank_run_next = blank_run + RunWidth'(1);
    end
    if (blank_run_next >= silent_frame_limit) begin
      code = STOP_SILENCE;
    end else if (frames_plus >= {1'b0, max_frames}) begin
      code = STOP_LIMIT;
    end else begin
      code = STOP_NONE;
    end
    result.frame_blank = blank;
    result.silent_run  = blank_run_next;
    result.frame_index = frames_done;
    result.stop_code   = code;
  end

  assign s1_fire = s1_valid && (finished || !frame_end || !skid_valid);
  assign push    = s1_fire && frame_end && !finished;
  assign pop     = out_valid && results.ready;
  assign in_fire = samples.valid && samples.ready;

  assign samples.ready = !rst && (!s1_valid || s1_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
    if (in_fire) begin
      s1_mag  <= in_mag;
      s1_loud <= in_mag > {2'b00, amplitude_threshold};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_in_frame <= '0;
      loud_count        <= '0;
      magnitude_sum     <= '0;
      blank_run         <= '0;
      frames_done       <= '0;
      finished          <= 1'b0;
    end else if (s1_fire && !finished) begin
      if (frame_end) begin
        position_in_frame <= '0;
        loud_count        <= '0;
        magnitude_sum     <= '0;
        blank_run         <= blank_run_next;
        frames_done       <= frames_plus[IndexWidth-1:0];
        finished          <= code != STOP_NONE;
      end else begin
        position_in_frame <= position_plus[LenWidth-1:0];
        loud_count        <= loud_count_next;
        magnitude_sum     <= magnitude_sum_next;
      end
    end
  end

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= result;
      end
    end else if (push) begin
      skid_data <= result;
    end
  end

  assign results.valid       = out_valid;
  assign results.frame_blank = out_data.frame_blank;
  assign results.silent_run  = out_data.silent_run;
  assign results.frame_index = out_data.frame_index;
  assign results.stop_code   = out_data.stop_code;

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a report while the output register is empty");

  assert property (@(posedge clk) disable iff (rst) push |-> !skid_valid)
    else $error("report pushed into a full output buffer");

  assert property (@(posedge clk) disable iff (rst) finished |=> finished)
    else $error("stop state left without reset");

  assert property (@(posedge clk) disable iff (rst)
      (push && code != STOP_NONE) |=> (finished && out_valid))
    else $error("stop report did not end the track");

endmodule
